// File: rtl/imu_offset_calibrate_integrate_assert.svh
// Assertion helpers shared by the checker.
`ifndef IMU_OFFSET_CALIBRATE_INTEGRATE_ASSERT_SVH
`define IMU_OFFSET_CALIBRATE_INTEGRATE_ASSERT_SVH

// Consequent in the next cycle, masked while in reset
`define IOCI_CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, masked while in reset
`define IOCI_CHK_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checked during reset too
`define IOCI_CHK_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ioci_pkg.sv
`default_nettype none
package ioci_pkg;

    // Largest supported calibration length, log2 of samples
    localparam int MAX_CALIB_LOG2_DEF = 12;

    // Configuration register
    localparam int                CFG_W          = 4;
    localparam logic [CFG_W-1:0]  CALIB_LOG2_RST = 4'd10;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 16;
    localparam int DT_W    = 20;
    localparam int CORR_W  = 17;
    localparam int ANGLE_W = 64;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Angle clamp limits
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

endpackage
`default_nettype wire

// File: rtl/imu_offset_calibrate_integrate.sv
`default_nettype none
// Gyro bias calibration and angle integration for one accelerometer axis and one
// gyro axis. After reset the first 2^calib_log2 samples (calib_log2 clamped to
// MAX_CALIB_LOG2) are summed to form both offsets and give no result; every later
// sample gives offset-corrected acceleration and rate plus a saturating 64-bit
// angle sum of rate times elapsed microseconds, with angle_saturated set while the
// sum sits at a limit. One request is taken per clock cycle while the queue is
// not full, calibration samples included; a result passes from front correction
// into the queue, then the multiply stage, then the accumulator and output
// register. A four-entry queue between front and back lets input keep flowing
// while the output side stalls, until the queue fills.
// Write calib_log2 only while the block is idle; the config port is always ready,
// and a change after calibration has finished has no effect until reset.
module imu_offset_calibrate_integrate #(
    parameter int MAX_CALIB_LOG2 = ioci_pkg::MAX_CALIB_LOG2_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ioci_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_accel_high,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_accel_low,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_gyro_high,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_gyro_low,
    input  wire logic [ioci_pkg::DT_W-1:0]         i_elapsed_us,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [ioci_pkg::CORR_W-1:0]     o_accel_corrected,
    output logic signed [ioci_pkg::CORR_W-1:0]     o_rate_corrected,
    output logic signed [ioci_pkg::ANGLE_W-1:0]    o_angle_sum,
    output logic                                   o_angle_saturated
);

    localparam int RC_W = ioci_pkg::RAW_W + MAX_CALIB_LOG2 + 2;
    localparam int Q_W  = ioci_pkg::CORR_W + RC_W + ioci_pkg::DT_W;

    logic                              w_q_full;
    logic                              w_push;
    logic [ioci_pkg::CORR_W-1:0]       w_f_accel;
    logic signed [RC_W-1:0]            w_f_rate;
    logic [ioci_pkg::DT_W-1:0]         w_f_dt;
    logic                              w_q_valid;
    logic                              w_q_ready;
    logic [Q_W-1:0]                    w_q_data;

    assign o_cfg_ready = 1'b1;

    // Front: config, calibration, offset correction
    ioci_front #(
        .MAX_CALIB_LOG2 (MAX_CALIB_LOG2),
        .RC_W           (RC_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_q_full     (w_q_full),
        .i_accel_high (i_accel_high),
        .i_accel_low  (i_accel_low),
        .i_gyro_high  (i_gyro_high),
        .i_gyro_low   (i_gyro_low),
        .i_elapsed_us (i_elapsed_us),
        .o_in_stall   (o_in_stall),
        .o_push       (w_push),
        .o_accel_corr (w_f_accel),
        .o_rate_corr  (w_f_rate),
        .o_dt         (w_f_dt)
    );

    // Decoupling queue
    ioci_queue #(
        .W     (Q_W),
        .DEPTH (ioci_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_accel, w_f_rate, w_f_dt}),
        .i_pop   (w_q_valid && w_q_ready),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // Back: multiply, saturating accumulate, output register
    ioci_back #(
        .RC_W (RC_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_accel_corr      (w_q_data[Q_W-1 -: ioci_pkg::CORR_W]),
        .i_rate_corr       ($signed(w_q_data[ioci_pkg::DT_W +: RC_W])),
        .i_dt              (w_q_data[ioci_pkg::DT_W-1:0]),
        .i_out_stall       (i_out_stall),
        .o_q_ready         (w_q_ready),
        .o_out_valid       (o_out_valid),
        .o_accel_corrected (o_accel_corrected),
        .o_rate_corrected  (o_rate_corrected),
        .o_angle_sum       (o_angle_sum),
        .o_angle_saturated (o_angle_saturated)
    );

endmodule
`default_nettype wire

// File: rtl/ioci_front.sv
`default_nettype none
module ioci_front #(
    parameter int MAX_CALIB_LOG2 = ioci_pkg::MAX_CALIB_LOG2_DEF,
    parameter int RC_W           = ioci_pkg::RAW_W + MAX_CALIB_LOG2 + 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [ioci_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_q_full,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_accel_high,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_accel_low,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_gyro_high,
    input  wire logic [ioci_pkg::BYTE_W-1:0]       i_gyro_low,
    input  wire logic [ioci_pkg::DT_W-1:0]         i_elapsed_us,
    output logic                                   o_in_stall,
    output logic                                   o_push,
    output logic [ioci_pkg::CORR_W-1:0]            o_accel_corr,
    output logic signed [RC_W-1:0]                 o_rate_corr,
    output logic [ioci_pkg::DT_W-1:0]              o_dt
);

    localparam int SUM_W = ioci_pkg::RAW_W + MAX_CALIB_LOG2 + 1;
    localparam int CNT_W = MAX_CALIB_LOG2 + 1;
    localparam int N_W   = $clog2(MAX_CALIB_LOG2 + 1);

    logic [ioci_pkg::CFG_W-1:0]     r_calib_log2;
    logic [CNT_W-1:0]               r_cnt;
    logic signed [SUM_W-1:0]        r_accel_sum;
    logic signed [SUM_W-1:0]        r_gyro_sum;
    logic signed [SUM_W-1:0]        r_accel_off;
    logic signed [SUM_W-1:0]        r_gyro_off;
    logic                           r_calibrated;

    logic signed [ioci_pkg::RAW_W-1:0] w_accel;
    logic signed [ioci_pkg::RAW_W-1:0] w_gyro;
    logic [N_W-1:0]                 w_n;
    logic [CNT_W-1:0]               n_cnt;
    logic [CNT_W-1:0]               w_lim;
    logic signed [SUM_W-1:0]        n_accel_sum;
    logic signed [SUM_W-1:0]        n_gyro_sum;
    logic signed [RC_W-1:0]         w_accel_diff;
    logic                           w_accept;
    logic                           w_done;

    // Request taken whenever the queue has room
    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;

    // Byte pairs, high byte first
    assign w_accel = $signed({i_accel_high, i_accel_low});
    assign w_gyro  = $signed({i_gyro_high, i_gyro_low});

    // Calibration length, clamped to the supported maximum
    assign w_n = (int'(r_calib_log2) > MAX_CALIB_LOG2) ? N_W'(MAX_CALIB_LOG2)
                                                       : N_W'(r_calib_log2);

    // Running sums and end-of-phase test
    assign n_accel_sum = r_accel_sum + SUM_W'(w_accel);
    assign n_gyro_sum  = r_gyro_sum + SUM_W'(w_gyro);
    assign n_cnt       = r_cnt + CNT_W'(1);
    assign w_lim       = CNT_W'(1) << w_n;
    assign w_done      = n_cnt >= w_lim;

    // Offset correction for measurement requests
    assign w_accel_diff = RC_W'(w_accel) - RC_W'(r_accel_off);
    assign o_accel_corr = w_accel_diff[ioci_pkg::CORR_W-1:0];
    assign o_rate_corr  = RC_W'(w_gyro) - RC_W'(r_gyro_off);
    assign o_dt         = i_elapsed_us;
    assign o_push       = w_accept && r_calibrated;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_log2 <= ioci_pkg::CALIB_LOG2_RST;
        end else if (i_cfg_valid) begin
            r_calib_log2 <= i_cfg_data;
        end
    end

    // Calibration accumulation; offsets latched on the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_accel_sum  <= '0;
            r_gyro_sum   <= '0;
            r_accel_off  <= '0;
            r_gyro_off   <= '0;
            r_calibrated <= 1'b0;
        end else if (w_accept && !r_calibrated) begin
            r_cnt       <= n_cnt;
            r_accel_sum <= n_accel_sum;
            r_gyro_sum  <= n_gyro_sum;
            if (w_done) begin
                r_accel_off  <= n_accel_sum >>> w_n;
                r_gyro_off   <= n_gyro_sum >>> w_n;
                r_calibrated <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/ioci_queue.sv
`default_nettype none
module ioci_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ioci_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ioci_back.sv
`default_nettype none
module ioci_back #(
    parameter int RC_W = ioci_pkg::RAW_W + ioci_pkg::MAX_CALIB_LOG2_DEF + 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    input  wire logic [ioci_pkg::CORR_W-1:0]       i_accel_corr,
    input  wire logic signed [RC_W-1:0]            i_rate_corr,
    input  wire logic [ioci_pkg::DT_W-1:0]         i_dt,
    input  wire logic                              i_out_stall,
    output logic                                   o_q_ready,
    output logic                                   o_out_valid,
    output logic signed [ioci_pkg::CORR_W-1:0]     o_accel_corrected,
    output logic signed [ioci_pkg::CORR_W-1:0]     o_rate_corrected,
    output logic signed [ioci_pkg::ANGLE_W-1:0]    o_angle_sum,
    output logic                                   o_angle_saturated
);

    localparam int PROD_W = RC_W + ioci_pkg::DT_W + 1;
    localparam int AW     = ioci_pkg::ANGLE_W;

    logic                               r_p_valid;
    logic [ioci_pkg::CORR_W-1:0]        r_p_accel;
    logic [ioci_pkg::CORR_W-1:0]        r_p_rate;
    logic signed [PROD_W-1:0]           r_p_prod;

    logic                               r_o_valid;
    logic [ioci_pkg::CORR_W-1:0]        r_o_accel;
    logic [ioci_pkg::CORR_W-1:0]        r_o_rate;
    logic signed [AW-1:0]               r_angle;
    logic                               r_sat;

    logic signed [PROD_W-1:0]           w_prod;
    logic signed [AW-1:0]               w_add;
    logic signed [AW-1:0]               w_sum;
    logic signed [AW-1:0]               n_angle;
    logic                               w_ovf;
    logic                               w_adv_o;

    // Handshake: output register frees, product stage moves up
    assign w_adv_o   = r_p_valid && (!r_o_valid || !i_out_stall);
    assign o_q_ready = !r_p_valid || w_adv_o;

    // Rate times elapsed time, dt taken as unsigned
    assign w_prod = i_rate_corr * $signed({1'b0, i_dt});

    // Saturating accumulate
    assign w_add = AW'(r_p_prod);
    assign w_sum = r_angle + w_add;
    assign w_ovf = (r_angle[AW-1] == w_add[AW-1]) && (w_sum[AW-1] != r_angle[AW-1]);
    always_comb begin
        n_angle = w_sum;
        if (w_ovf) begin
            n_angle = r_angle[AW-1] ? ioci_pkg::ANGLE_MIN : ioci_pkg::ANGLE_MAX;
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_q_ready) begin
            r_p_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_ready && i_q_valid) begin
            r_p_accel <= i_accel_corr;
            r_p_rate  <= i_rate_corr[ioci_pkg::CORR_W-1:0];
            r_p_prod  <= w_prod;
        end
    end

    // Output register and angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_angle   <= '0;
            r_sat     <= 1'b0;
        end else if (w_adv_o) begin
            r_o_valid <= 1'b1;
            r_angle   <= n_angle;
            r_sat     <= (n_angle == ioci_pkg::ANGLE_MIN) || (n_angle == ioci_pkg::ANGLE_MAX);
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_o) begin
            r_o_accel <= r_p_accel;
            r_o_rate  <= r_p_rate;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_accel_corrected = $signed(r_o_accel);
    assign o_rate_corrected  = $signed(r_o_rate);
    assign o_angle_sum       = r_angle;
    assign o_angle_saturated = r_sat;

endmodule
`default_nettype wire

// File: rtl/ioci_checker.sv
`default_nettype none
`include "imu_offset_calibrate_integrate_assert.svh"
module ioci_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_in_stall,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic signed [ioci_pkg::CORR_W-1:0]  o_accel_corrected,
    input  wire logic signed [ioci_pkg::CORR_W-1:0]  o_rate_corrected,
    input  wire logic signed [ioci_pkg::ANGLE_W-1:0] o_angle_sum,
    input  wire logic                              o_angle_saturated
);

    // A stalled result holds until taken
    `IOCI_CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_accel_corrected) && $stable(o_rate_corrected) && $stable(o_angle_sum) && $stable(o_angle_saturated), "stalled result changed")

    // Saturation flag matches the angle value shown
    `IOCI_CHK_NOW(a_sat_flag, i_clk, i_rst_n, o_out_valid, o_angle_saturated == ((o_angle_sum == ioci_pkg::ANGLE_MIN) || (o_angle_sum == ioci_pkg::ANGLE_MAX)), "saturation flag mismatch")

    // Reset empties the output register
    `IOCI_CHK_RST(a_rst_out, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

    // Reset empties the queue, so input is not stalled
    `IOCI_CHK_RST(a_rst_in, i_clk, !i_rst_n, !o_in_stall, "input stalled after reset")

endmodule

bind imu_offset_calibrate_integrate ioci_checker u_ioci_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_accel_corrected (o_accel_corrected),
    .o_rate_corrected  (o_rate_corrected),
    .o_angle_sum       (o_angle_sum),
    .o_angle_saturated (o_angle_saturated)
);
`default_nettype wire

// File: tb/imu_angle_checker.sv
`default_nettype none
module imu_angle_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic                                i_cfg_ready,
    input  wire logic [ioci_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic [ioci_pkg::BYTE_W-1:0]         i_accel_high,
    input  wire logic [ioci_pkg::BYTE_W-1:0]         i_accel_low,
    input  wire logic [ioci_pkg::BYTE_W-1:0]         i_gyro_high,
    input  wire logic [ioci_pkg::BYTE_W-1:0]         i_gyro_low,
    input  wire logic [ioci_pkg::DT_W-1:0]           i_elapsed_us,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic signed [ioci_pkg::CORR_W-1:0]  i_accel_corrected,
    input  wire logic signed [ioci_pkg::CORR_W-1:0]  i_rate_corrected,
    input  wire logic signed [ioci_pkg::ANGLE_W-1:0] i_angle_sum,
    input  wire logic                                i_angle_saturated,
    output int                                       o_errors,
    output int                                       o_pending,
    output int                                       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ioci_pkg::CORR_W-1:0]  accel;
        logic signed [ioci_pkg::CORR_W-1:0]  rate;
        logic signed [ioci_pkg::ANGLE_W-1:0] angle;
        logic                                sat;
    } t_imu_result;

    t_imu_result predicted_results[$];

    // Model copy of the block state
    logic [ioci_pkg::CFG_W-1:0]   calib_len_log2;
    int unsigned                  calib_samples;
    longint                       accel_total;
    longint                       gyro_total;
    int                           accel_bias;
    int                           gyro_bias;
    bit                           bias_ready;
    logic [ioci_pkg::ANGLE_W-1:0] angle_acc;

    function automatic int raw_s16(logic [ioci_pkg::BYTE_W-1:0] hi,
                                   logic [ioci_pkg::BYTE_W-1:0] lo);
        logic signed [ioci_pkg::RAW_W-1:0] v;
        v = {hi, lo};
        return int'(v);
    endfunction

    // Calibrate on early samples, then correct and integrate the rate
    function automatic void integrate_sample(logic [ioci_pkg::BYTE_W-1:0] ah,
                                             logic [ioci_pkg::BYTE_W-1:0] al,
                                             logic [ioci_pkg::BYTE_W-1:0] gh,
                                             logic [ioci_pkg::BYTE_W-1:0] gl,
                                             logic [ioci_pkg::DT_W-1:0] dt);
        int                           a;
        int                           g;
        int                           ac;
        int                           rc;
        int                           n;
        longint                       dt_l;
        longint                       prod;
        logic [ioci_pkg::ANGLE_W-1:0] sum;
        t_imu_result                  res;
        a = raw_s16(ah, al);
        g = raw_s16(gh, gl);
        if (!bias_ready) begin
            n = (calib_len_log2 > ioci_pkg::MAX_CALIB_LOG2_DEF) ? ioci_pkg::MAX_CALIB_LOG2_DEF
                                                               : int'(calib_len_log2);
            accel_total += a;
            gyro_total  += g;
            calib_samples++;
            if (calib_samples >= (32'd1 << n)) begin
                // arithmetic shift floors toward minus infinity
                accel_bias = int'(accel_total >>> n);
                gyro_bias  = int'(gyro_total >>> n);
                bias_ready = 1'b1;
            end
            return;
        end
        ac   = a - accel_bias;
        rc   = g - gyro_bias;
        dt_l = longint'(dt);
        prod = longint'(rc) * dt_l;
        sum  = angle_acc + prod;
        // clamp on signed overflow
        if (angle_acc[ioci_pkg::ANGLE_W-1] == prod[63]
            && sum[ioci_pkg::ANGLE_W-1] != angle_acc[ioci_pkg::ANGLE_W-1])
            sum = angle_acc[ioci_pkg::ANGLE_W-1] ? ioci_pkg::ANGLE_MIN : ioci_pkg::ANGLE_MAX;
        angle_acc = sum;
        res.accel = ac[ioci_pkg::CORR_W-1:0];
        res.rate  = rc[ioci_pkg::CORR_W-1:0];
        res.angle = angle_acc;
        res.sat   = (angle_acc == ioci_pkg::ANGLE_MIN) || (angle_acc == ioci_pkg::ANGLE_MAX);
        predicted_results.push_back(res);
    endfunction

    // Watch all three channels at the rising edge
    always @(posedge i_clk) begin
        t_imu_result exp_res;
        if (!i_rst_n) begin
            calib_len_log2 = ioci_pkg::CALIB_LOG2_RST;
            calib_samples  = 0;
            accel_total    = 0;
            gyro_total     = 0;
            accel_bias     = 0;
            gyro_bias      = 0;
            bias_ready     = 1'b0;
            angle_acc      = '0;
            predicted_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                calib_len_log2 = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                integrate_sample(i_accel_high, i_accel_low, i_gyro_high, i_gyro_low,
                                 i_elapsed_us);
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (predicted_results.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result with none pending: accel %0d rate %0d angle %0d",
                                 $realtime, i_accel_corrected, i_rate_corrected, i_angle_sum);
                    o_errors++;
                end else begin
                    exp_res = predicted_results.pop_front();
                    if (exp_res.accel !== i_accel_corrected || exp_res.rate !== i_rate_corrected
                        || exp_res.angle !== i_angle_sum
                        || exp_res.sat !== i_angle_saturated) begin
                        if (o_errors < 10) begin
                            $display("%0t: mismatch: accel exp %0d got %0d, rate exp %0d got %0d",
                                     $realtime, exp_res.accel, i_accel_corrected,
                                     exp_res.rate, i_rate_corrected);
                            $display("    angle exp %0d got %0d, saturated exp %0b got %0b",
                                     exp_res.angle, i_angle_sum, exp_res.sat,
                                     i_angle_saturated);
                        end
                        o_errors++;
                    end
                end
            end
        end
        o_pending = predicted_results.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY_WAIT   = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 205;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [ioci_pkg::CFG_W-1:0]          i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [ioci_pkg::BYTE_W-1:0]         i_accel_high;
    logic [ioci_pkg::BYTE_W-1:0]         i_accel_low;
    logic [ioci_pkg::BYTE_W-1:0]         i_gyro_high;
    logic [ioci_pkg::BYTE_W-1:0]         i_gyro_low;
    logic [ioci_pkg::DT_W-1:0]           i_elapsed_us;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic signed [ioci_pkg::CORR_W-1:0]  o_accel_corrected;
    logic signed [ioci_pkg::CORR_W-1:0]  o_rate_corrected;
    logic signed [ioci_pkg::ANGLE_W-1:0] o_angle_sum;
    logic                                o_angle_saturated;

    int  mismatch_count;
    int  results_pending;
    int  results_checked;
    int  samples_sent;
    int  cfg_writes;
    int  idle_cycles;
    int  stall_hold;
    int  stall_roll;
    bit  steady;

    imu_offset_calibrate_integrate dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_accel_high      (i_accel_high),
        .i_accel_low       (i_accel_low),
        .i_gyro_high       (i_gyro_high),
        .i_gyro_low        (i_gyro_low),
        .i_elapsed_us      (i_elapsed_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accel_corrected (o_accel_corrected),
        .o_rate_corrected  (o_rate_corrected),
        .o_angle_sum       (o_angle_sum),
        .o_angle_saturated (o_angle_saturated)
    );

    imu_angle_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_accel_high      (i_accel_high),
        .i_accel_low       (i_accel_low),
        .i_gyro_high       (i_gyro_high),
        .i_gyro_low        (i_gyro_low),
        .i_elapsed_us      (i_elapsed_us),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_accel_corrected (o_accel_corrected),
        .i_rate_corrected  (o_rate_corrected),
        .i_angle_sum       (o_angle_sum),
        .i_angle_saturated (o_angle_saturated),
        .o_errors          (mismatch_count),
        .o_pending         (results_pending),
        .o_checked         (results_checked)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output back-pressure: mostly short stalls, a few long ones
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (steady) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= (stall_roll < 95) ? $urandom_range(0, 3)
                                                 : $urandom_range(15, 40);
            end
        end
    end

    // Watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // High bytes lean towards the sign boundaries
    function automatic logic [ioci_pkg::BYTE_W-1:0] pick_byte(bit edgy);
        int r;
        r = $urandom_range(0, 99);
        if (!edgy || r < 70)
            return ioci_pkg::BYTE_W'($urandom_range(0, 255));
        case (r % 4)
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic [ioci_pkg::DT_W-1:0] pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return ioci_pkg::DT_W'($urandom_range(0, (1 << ioci_pkg::DT_W) - 1));
        if (r < 85)
            return ioci_pkg::DT_W'($urandom_range(0, 15));
        return ioci_pkg::DT_W'($urandom_range((1 << ioci_pkg::DT_W) - 16,
                                              (1 << ioci_pkg::DT_W) - 1));
    endfunction

    task automatic send_sample(input logic [ioci_pkg::BYTE_W-1:0] ah,
                               input logic [ioci_pkg::BYTE_W-1:0] al,
                               input logic [ioci_pkg::BYTE_W-1:0] gh,
                               input logic [ioci_pkg::BYTE_W-1:0] gl,
                               input logic [ioci_pkg::DT_W-1:0] dt);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_accel_high <= ah;
        i_accel_low  <= al;
        i_gyro_high  <= gh;
        i_gyro_low   <= gl;
        i_elapsed_us <= dt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    // Hold the sender until every predicted result is out, then let the pipe empty
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (LATENCY_WAIT) @(negedge i_clk);
    endtask

    task automatic set_calib_length(input logic [ioci_pkg::CFG_W-1:0] len_log2);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len_log2;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int                         phase;
        int                         k;
        logic [ioci_pkg::CFG_W-1:0] len_log2;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_accel_high = '0;
        i_accel_low  = '0;
        i_gyro_high  = '0;
        i_gyro_low   = '0;
        i_elapsed_us = '0;
        i_out_stall  = 1'b0;
        stall_hold   = 0;
        steady       = 1'b0;
        samples_sent = 0;
        cfg_writes   = 0;
        idle_cycles  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Out-of-range length first, shortened mid-calibration
        set_calib_length(4'd15);
        send_sample(8'h7F, 8'hFF, 8'h80, 8'h00, pick_dt());
        send_sample(8'h7F, 8'hFF, 8'h80, 8'h00, pick_dt());
        set_calib_length(4'd2);
        // gyro sum of -2 over four samples floors to -1
        send_sample(8'h7F, 8'hFF, 8'h7F, 8'hFF, pick_dt());
        send_sample(8'h7F, 8'hFF, 8'h7F, 8'hFF, pick_dt());

        // Corrected samples at the field extremes
        send_sample(8'h80, 8'h00, 8'h7F, 8'hFF, 20'hFFFFF);
        send_sample(8'h7F, 8'hFF, 8'h80, 8'h00, 20'hFFFFF);
        send_sample(8'h00, 8'h00, 8'h00, 8'h00, 20'h00000);
        send_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF, 20'h00000);
        send_sample(8'h80, 8'h00, 8'h80, 8'h00, 20'hFFFFF);
        send_sample(8'h55, 8'hAA, 8'hAA, 8'h55, 20'h55555);
        send_sample(8'hAA, 8'h55, 8'h55, 8'hAA, 20'hAAAAA);
        send_sample(8'h7F, 8'hFF, 8'hFF, 8'hFF, 20'd12345);
        send_sample(8'h01, 8'h00, 8'h7F, 8'h00, 20'd1);

        // Random phases; length writes after calibration must not change anything
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       len_log2 = 4'd0;
                1:       len_log2 = 4'd15;
                2:       len_log2 = 4'd12;
                3:       len_log2 = 4'd1;
                default: len_log2 = ioci_pkg::CFG_W'($urandom_range(0, 15));
            endcase
            set_calib_length(len_log2);
            steady = (phase % 3 == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_byte(1'b1), pick_byte(1'b0), pick_byte(1'b1),
                            pick_byte(1'b0), pick_dt());
            steady = 1'b0;
        end

        drain_results();
        $display("Summary: %0d samples sent (4 for bias calibration), %0d results checked.",
                 samples_sent, results_checked);
        $display("Summary: %0d length writes incl. 0, 12 and 15; stalled and gap-free phases.",
                 cfg_writes);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
